@@ src/dsg_pkg.sv @@
// Shared types and constants for the dash segment generator.
// Used by dsg_ctrl, dsg_datapath and dash_segment_generator.
`timescale 1ns / 1ps
`default_nettype none

package dsg_pkg;

  localparam int COORD_W   = 32;
  localparam int NUM_PTS   = 6;
  localparam int DATA_W    = NUM_PTS * COORD_W;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 4;
  localparam int USER_W    = 3;
  localparam int STEP_W    = 6;
  localparam int ACC_W     = 66;  // sum of three 32-bit squares
  localparam int ROOT_W    = 34;  // root register while the root is built
  localparam int LEN_W     = 33;  // final root
  localparam int SREM_W    = 36;
  localparam int Q_W       = 29;  // unit vector magnitude, Q1.28, <= 2^28
  localparam int T_W       = 33;  // offset along the line, Q17.16
  localparam int POS_W     = 32;  // used / left
  localparam int PROD_W    = Q_W + T_W;
  localparam int OFF_W     = 35;
  localparam int WIDE_W    = 37;

  localparam logic [CFG_IDX_W-1:0] REG_DASH_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DASH_GAP    = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] DASH_LENGTH_RST = CFG_W'(9830);
  localparam logic [CFG_W-1:0] DASH_GAP_RST    = CFG_W'(29491);
  localparam logic [CFG_W:0]   HALF_Q16        = (CFG_W+1)'(32768);

  // out_tuser bit positions
  localparam int USR_VALID   = 0;
  localparam int USR_SET_END = 1;
  localparam int USR_TRUNC   = 2;

  // 66-bit radicand: 33 steps of two bits each
  localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(3);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(32);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(28);
  localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(6);

  typedef enum logic [1:0] {
    RK_NONE,
    RK_LINE,
    RK_SIDE0,
    RK_SIDE1
  } res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_CHECK,
    S_SQRT,
    S_DIV,
    S_TEST,
    S_MUL,
    S_SIDE0,
    S_SIDE1,
    S_LINE,
    S_DONE,
    S_FLUSH
  } dsg_state_t;

  typedef struct packed {
    logic              load;
    logic              sq_step;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              div_step;
    logic              loop_reg;
    logic              loop_fin;
    logic              mul_step;
    logic              mark_drop;
    logic              push;
    res_kind_t         kind;
    logic              flush;
    logic [STEP_W-1:0] step;
  } dsg_cmd_t;

  typedef struct packed {
    logic s_long;
    logic gap_big;
    logic len_big;
    logic left_gt_sum;
    logic left_gt_gap;
    logic full;
    logic hold_v;
    logic can_push;
  } dsg_status_t;

  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v > WIDE_W'(signed'(33'sh07fffffff))) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < WIDE_W'(signed'(33'sh180000000))) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/dsg_ctrl.sv @@
// Controller state machine for the dash segment generator.
// Depends on dsg_pkg; drives dsg_datapath through dsg_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module dsg_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  dsg_pkg::dsg_status_t status,
  output dsg_pkg::dsg_cmd_t   cmd
);
  import dsg_pkg::*;

  dsg_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              fin_r, fin_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + STEP_W'(1);
    fin_nxt   = fin_r;
    case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (in_valid) state_nxt = S_SQ;
      end
      S_SQ: begin
        if (step_r == SQ_LAST) begin
          step_nxt = '0;
          if (status.s_long && status.gap_big) state_nxt = S_CHECK;
          else state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        step_nxt = '0;
        if (status.s_long && status.gap_big) state_nxt = S_SQRT;
        else if (status.s_long && status.len_big) state_nxt = S_LINE;
        else state_nxt = S_DONE;
      end
      S_SQRT: begin
        if (step_r == SQRT_LAST) begin
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (step_r == DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        step_nxt = '0;
        if (status.left_gt_sum || status.left_gt_gap) begin
          state_nxt = S_MUL;
          fin_nxt   = !status.left_gt_sum;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        if (step_r == MUL_LAST) begin
          step_nxt  = '0;
          state_nxt = S_SIDE0;
        end
      end
      S_SIDE0: begin
        step_nxt = '0;
        if (status.full) state_nxt = S_DONE;
        else if (status.can_push) state_nxt = S_SIDE1;
      end
      S_SIDE1: begin
        step_nxt = '0;
        if (status.full) state_nxt = S_DONE;
        else if (status.can_push) state_nxt = fin_r ? S_DONE : S_TEST;
      end
      S_LINE: begin
        step_nxt = '0;
        if (status.can_push) state_nxt = S_DONE;
      end
      S_DONE: begin
        step_nxt  = '0;
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        step_nxt = '0;
        if (status.can_push) state_nxt = S_IDLE;
      end
      default: begin
        step_nxt  = '0;
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.kind = RK_NONE;
    cmd.step = step_r;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SQ:    cmd.sq_step = 1'b1;
      S_CHECK: cmd.sqrt_init = status.s_long && status.gap_big;
      S_SQRT:  cmd.sqrt_step = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_TEST: begin
        cmd.loop_reg = status.left_gt_sum;
        cmd.loop_fin = !status.left_gt_sum && status.left_gt_gap;
      end
      S_MUL:   cmd.mul_step = 1'b1;
      S_SIDE0: begin
        cmd.mark_drop = status.full;
        cmd.push      = !status.full && status.can_push;
        cmd.kind      = RK_SIDE0;
      end
      S_SIDE1: begin
        cmd.mark_drop = status.full;
        cmd.push      = !status.full && status.can_push;
        cmd.kind      = RK_SIDE1;
      end
      S_LINE: begin
        cmd.push = status.can_push;
        cmd.kind = RK_LINE;
      end
      S_DONE: begin
        // nothing held: the pair gave no dash
        cmd.push = !status.hold_v;
        cmd.kind = RK_NONE;
      end
      S_FLUSH: cmd.flush = status.can_push;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/dsg_datapath.sv @@
// Datapath of the dash segment generator: squarer, bit-serial square root,
// three-lane divider, offset multiplier, result hold and output registers.
// Depends on dsg_pkg; controlled by dsg_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module dsg_datapath #(
  parameter int MAX_SEGMENTS    = 64,
  parameter int SMALL_THRESHOLD = 7
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  dsg_pkg::dsg_cmd_t                  cmd,
  output dsg_pkg::dsg_status_t               status,
  input  wire  [dsg_pkg::DATA_W-1:0]         in_tdata,
  input  wire                                in_tlast,
  input  wire                                cfg_valid,
  input  wire  [dsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [dsg_pkg::CFG_W-1:0]          cfg_data,
  output logic [dsg_pkg::DATA_W-1:0]         out_tdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic                               out_tlast,
  output logic [dsg_pkg::USER_W-1:0]         out_tuser
);
  import dsg_pkg::*;

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);
  localparam logic [ACC_W-1:0] THR_SQ  = ACC_W'(SMALL_THRESHOLD) * ACC_W'(SMALL_THRESHOLD);
  localparam logic [LEN_W-1:0] THR     = LEN_W'(SMALL_THRESHOLD);

  // configuration
  logic [CFG_W-1:0] len_r, gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= DASH_LENGTH_RST;
      gap_r <= DASH_GAP_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DASH_LENGTH) len_r <= cfg_data;
      else if (cfg_index == REG_DASH_GAP) gap_r <= cfg_data;
    end
  end

  logic [CFG_W:0]   sum_raw, sum_eff;
  logic [CFG_W-1:0] half_gap;

  assign sum_raw  = {1'b0, len_r} + {1'b0, gap_r};
  assign sum_eff  = (LEN_W'(sum_raw) < THR) ? HALF_Q16 : sum_raw;
  assign half_gap = gap_r >> 1;

  // points, differences, midpoints
  logic [COORD_W-1:0] pt_r [NUM_PTS];
  logic               final_r;
  logic [COORD_W-1:0] mag [3];
  logic               dneg [3];
  logic [COORD_W-1:0] mid [3];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NUM_PTS; i++) pt_r[i] <= in_tdata[i*COORD_W +: COORD_W];
      final_r <= in_tlast;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [COORD_W:0] dif, neg_dif, msum;
      dif     = {pt_r[a+3][COORD_W-1], pt_r[a+3]} - {pt_r[a][COORD_W-1], pt_r[a]};
      neg_dif = -dif;
      msum    = {pt_r[a+3][COORD_W-1], pt_r[a+3]} + {pt_r[a][COORD_W-1], pt_r[a]};
      dneg[a] = dif[COORD_W];
      mag[a]  = dif[COORD_W] ? neg_dif[COORD_W-1:0] : dif[COORD_W-1:0];
      mid[a]  = msum[COORD_W:1];
    end
  end

  // sum of squares, one axis a cycle
  logic [COORD_W-1:0]   sq_sel;
  logic [2*COORD_W-1:0] sq_prod_r;
  logic [ACC_W-1:0]     acc_r;

  always_comb begin
    case (cmd.step[1:0])
      2'd0:    sq_sel = mag[0];
      2'd1:    sq_sel = mag[1];
      2'd2:    sq_sel = mag[2];
      default: sq_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= '0;
    end else if (cmd.sq_step) begin
      sq_prod_r <= sq_sel * sq_sel;
      if (cmd.step != '0) acc_r <= acc_r + ACC_W'(sq_prod_r);
    end
  end

  // square root, two radicand bits a cycle
  logic [ACC_W-1:0]  rad_r;
  logic [SREM_W-1:0] srem_r;
  logic [ROOT_W-1:0] root_r;
  logic [SREM_W+1:0] srem_t, strial;
  logic [LEN_W-1:0]  len_l;

  assign srem_t = {srem_r, rad_r[ACC_W-1 -: 2]};
  assign strial = {2'b00, root_r, 2'b01};
  assign len_l  = root_r[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rad_r  <= acc_r;
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= rad_r << 2;
      if (srem_t >= strial) begin
        srem_r <= SREM_W'(srem_t - strial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        srem_r <= srem_t[SREM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // unit vector: three restoring-division lanes, one quotient bit a cycle
  logic [Q_W-1:0]   q_r [3];
  logic [LEN_W-1:0] drem_r [3];

  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      for (int a = 0; a < 3; a++) begin
        logic [LEN_W:0] t;
        t = (cmd.step == '0) ? {2'b00, mag[a]} : {drem_r[a], 1'b0};
        if (t >= {1'b0, len_l}) begin
          drem_r[a] <= LEN_W'(t - {1'b0, len_l});
          q_r[a]    <= {q_r[a][Q_W-2:0], 1'b1};
        end else begin
          drem_r[a] <= t[LEN_W-1:0];
          q_r[a]    <= {q_r[a][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  // dash walk
  logic [POS_W-1:0] left_r, used_r, left_fin;
  logic [T_W-1:0]   p1_r, p2_r;

  assign left_fin = left_r - POS_W'(gap_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      used_r <= '0;
    end else if (cmd.div_step && cmd.step == '0) begin
      left_r <= POS_W'(len_l >> 1);
    end else if (cmd.loop_reg) begin
      p1_r   <= T_W'(used_r) + T_W'(half_gap);
      p2_r   <= T_W'(used_r) + T_W'(len_r) + T_W'(half_gap);
      left_r <= left_r - POS_W'(sum_eff);
      used_r <= used_r + POS_W'(sum_eff);
    end else if (cmd.loop_fin) begin
      p1_r   <= T_W'(used_r) + T_W'(half_gap);
      p2_r   <= T_W'(used_r) + T_W'(left_fin) + T_W'(half_gap);
      left_r <= left_fin;
    end
  end

  // offsets: six products through one multiplier
  logic [Q_W-1:0]    q_sel;
  logic [T_W-1:0]    t_sel;
  logic [PROD_W-1:0] mprod_r;
  logic [OFF_W-1:0]  off_r [NUM_PTS];
  logic [PROD_W:0]   rnd;
  logic [2:0]        off_idx;

  always_comb begin
    case (cmd.step)
      STEP_W'(0), STEP_W'(3): q_sel = q_r[0];
      STEP_W'(1), STEP_W'(4): q_sel = q_r[1];
      STEP_W'(2), STEP_W'(5): q_sel = q_r[2];
      default:                q_sel = '0;
    endcase
    t_sel   = (cmd.step < STEP_W'(3)) ? p1_r : p2_r;
    rnd     = {1'b0, mprod_r} + (PROD_W+1)'(1 << 27);
    off_idx = 3'(cmd.step - STEP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      mprod_r <= PROD_W'(q_sel) * PROD_W'(t_sel);
      if (cmd.step != '0) off_r[off_idx] <= OFF_W'(rnd >> 28);
    end
  end

  // new result
  logic [DATA_W-1:0] new_data;
  logic              new_seg_v;

  always_comb begin
    new_data  = '0;
    new_seg_v = 1'b0;
    case (cmd.kind)
      RK_LINE: begin
        for (int i = 0; i < NUM_PTS; i++) new_data[i*COORD_W +: COORD_W] = pt_r[i];
        new_seg_v = 1'b1;
      end
      RK_SIDE0, RK_SIDE1: begin
        for (int a = 0; a < 3; a++) begin
          logic              neg;
          logic [WIDE_W-1:0] mw, o1, o2;
          neg = dneg[a] ^ (cmd.kind == RK_SIDE1);
          mw  = {{(WIDE_W-COORD_W){mid[a][COORD_W-1]}}, mid[a]};
          o1  = WIDE_W'(off_r[a]);
          o2  = WIDE_W'(off_r[a+3]);
          new_data[a*COORD_W +: COORD_W]     = sat_coord(mw + (neg ? -o1 : o1));
          new_data[(a+3)*COORD_W +: COORD_W] = sat_coord(mw + (neg ? -o2 : o2));
        end
        new_seg_v = 1'b1;
      end
      default: begin
        new_data  = '0;
        new_seg_v = 1'b0;
      end
    endcase
  end

  // one result held back until it is known whether it is the pair's last
  logic [DATA_W-1:0] hold_data_r;
  logic              hold_seg_v_r;
  logic              hold_v_r;
  logic [CNT_W-1:0]  count_r;
  logic              dropped_r;
  logic [DATA_W-1:0] out_data_r;
  logic [USER_W-1:0] out_user_r;
  logic              out_last_r;
  logic              out_v_r;
  logic              out_free;
  logic [USER_W-1:0] body_user, tail_user;

  assign out_free = !out_v_r || out_tready;

  always_comb begin
    body_user              = '0;
    body_user[USR_VALID]   = hold_seg_v_r;
    tail_user              = body_user;
    tail_user[USR_SET_END] = final_r;
    tail_user[USR_TRUNC]   = dropped_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      if (cmd.load) begin
        count_r   <= '0;
        dropped_r <= 1'b0;
      end
      if (cmd.mark_drop) dropped_r <= 1'b1;
      if (cmd.push) begin
        hold_v_r <= 1'b1;
        count_r  <= count_r + CNT_W'(1);
        if (hold_v_r) out_v_r <= 1'b1;
      end
      if (cmd.flush) begin
        hold_v_r <= 1'b0;
        out_v_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      hold_data_r  <= new_data;
      hold_seg_v_r <= new_seg_v;
      if (hold_v_r) begin
        out_data_r <= hold_data_r;
        out_user_r <= body_user;
        out_last_r <= 1'b0;
      end
    end else if (cmd.flush) begin
      out_data_r <= hold_data_r;
      out_user_r <= tail_user;
      out_last_r <= 1'b1;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_v_r;

  always_comb begin
    status.s_long      = acc_r > THR_SQ;
    status.gap_big     = LEN_W'(gap_r) > THR;
    status.len_big     = LEN_W'(len_r) > THR;
    status.left_gt_sum = left_r > POS_W'(sum_eff);
    status.left_gt_gap = left_r > POS_W'(gap_r);
    status.full        = count_r >= CNT_MAX;
    status.hold_v      = hold_v_r;
    status.can_push    = !hold_v_r || out_free;
  end

endmodule

`default_nettype wire

@@ src/dash_segment_generator.sv @@
// Dash segment generator: cuts the line between two Q16.16 points into dashes
// mirrored about its midpoint. One item at a time: accept, squares, a 33-step square
// root, the divider, then the offset products and two results per dash pair, then
// closing the item. Pairs that fail the first check skip the root and the divider.
// Output stalls hold the result states.
// Synchronous active-low reset: idle, no results pending, dash length 9830, gap 29491.
`timescale 1ns / 1ps
`default_nettype none

module dash_segment_generator #(
  parameter int MAX_SEGMENTS    = 64,
  parameter int SMALL_THRESHOLD = 7
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // first_x, first_y, first_z, second_x, second_y, second_z (32 bits each)
  input  wire  [dsg_pkg::DATA_W-1:0]      in_tdata,
  input  wire                             in_tlast,   // final_pair
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z (32 bits each)
  output logic [dsg_pkg::DATA_W-1:0]      out_tdata,
  // segment_valid, set_end, truncated
  output logic [dsg_pkg::USER_W-1:0]      out_tuser,
  output logic                            out_tlast,  // last_of_pair
  output logic                            out_tvalid,
  input  wire                             out_tready,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [dsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [dsg_pkg::CFG_W-1:0]       cfg_data
);
  import dsg_pkg::*;

  dsg_cmd_t    cmd;
  dsg_status_t status;

  assign cfg_ready = 1'b1;

  dsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dsg_datapath #(
    .MAX_SEGMENTS    (MAX_SEGMENTS),
    .SMALL_THRESHOLD (SMALL_THRESHOLD)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
